// ----- hdl/itrd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package itrd_pkg;

  localparam int unsigned ValueW = 64;   // input word width
  localparam int unsigned RadixW = 6;    // radix register and digit value width
  localparam int unsigned CharW = 7;     // ASCII code width
  localparam int unsigned CharBusW = 8;  // output tdata, padded to a byte

  localparam int unsigned DefNumberWidth = 64;

  localparam logic [RadixW-1:0] RadixReset = RadixW'(10);
  localparam logic [RadixW-1:0] MinBase = RadixW'(2);
  localparam logic [RadixW-1:0] MaxBase = RadixW'(62);

  localparam logic [CharW-1:0] CharZero = CharW'(48);
  localparam logic [CharW-1:0] LowerOffset = CharW'(87);
  localparam logic [CharW-1:0] UpperOffset = CharW'(29);
  localparam logic [RadixW-1:0] LastDecimal = RadixW'(9);
  localparam logic [RadixW-1:0] LastLower = RadixW'(35);

  // 0-9 -> '0'-'9', 10-35 -> 'a'-'z', 36-61 -> 'A'-'Z'
  function automatic logic [CharW-1:0] digit_to_ascii(logic [RadixW-1:0] d);
    logic [CharW-1:0] dx;
    dx = CharW'(d);
    if (d <= LastDecimal) begin
      return dx + CharZero;
    end else if (d <= LastLower) begin
      return dx + LowerOffset;
    end else begin
      return dx + UpperOffset;
    end
  endfunction

endpackage

`default_nettype wire

// ----- hdl/integer_to_radix_digits_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Radix digit emitter: takes one unsigned NUMBER_WIDTH-bit word (upper bits of
// the 64-bit input are ignored) and sends its digits in the base held in the
// radix register (2..62; 0 and 1 act as 2, 63 acts as 62) as ASCII words, most
// significant first, without leading zeros; zero gives a single '0'. tlast
// marks the final digit. The block takes one number at a time. It first walks
// up the powers of the base with one shared 64x6 multiplier, storing each
// power in a small internal memory (P powers fit, P = 64 for base 2). It then
// walks back down that memory and finds each digit by a 6-step restoring
// division of the remainder by the power: a memory read, then six divide steps
// per power, then for each digit after the leading zeros a word that is held
// until the sink takes it. Write the radix only while the block is idle.
module integer_to_radix_digits_top #(
  parameter int unsigned NUMBER_WIDTH = itrd_pkg::DefNumberWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // radix register
  input  wire logic                          cfg_we_i,
  input  wire logic [itrd_pkg::RadixW-1:0]   cfg_wdata_i,
  // number in
  input  wire logic                          s_axis_tvalid_i,
  output      logic                          s_axis_tready_o,
  input  wire logic [itrd_pkg::ValueW-1:0]   s_axis_tdata_i,   // [63:0] value
  // digits out
  output      logic                          m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output      logic [itrd_pkg::CharBusW-1:0] m_axis_tdata_o,   // [6:0] digit_char, [7] zero
  output      logic                          m_axis_tlast_o
);

  import itrd_pkg::*;

  localparam int unsigned W = NUMBER_WIDTH;
  localparam int unsigned IdxW = $clog2(NUMBER_WIDTH);
  localparam int unsigned ProdW = W + RadixW;
  localparam int unsigned BitW = $clog2(RadixW);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StFind = 5'b00010,
    StLoad = 5'b00100,
    StDiv  = 5'b01000,
    StEmit = 5'b10000
  } state_e;

  state_e             state_q, state_d;
  logic [RadixW-1:0]  radix_q;
  logic [IdxW-1:0]    idx_q, idx_d;       // current power index
  logic [BitW-1:0]    bit_q, bit_d;       // quotient bit being tried
  logic               started_q, started_d;
  logic               last_q, last_d;

  logic [W-1:0]       pow_q, pow_d;       // power under construction
  logic [W-1:0]       rem_q, rem_d;       // remainder
  logic [RadixW-1:0]  quo_q, quo_d;       // partial digit
  logic [CharW-1:0]   char_q, char_d;
  logic [W-1:0]       rd_q;               // registered memory read

  // Powers of the base, index 0 = 1.
  logic [W-1:0]       pow_mem [NUMBER_WIDTH];

  logic [RadixW-1:0]  base;
  logic [ProdW-1:0]   prod;
  logic               fits;
  logic [ProdW-1:0]   trial;
  logic               ge;
  logic [RadixW-1:0]  digit;
  logic               emit_now;

  always_comb begin
    if (radix_q < MinBase) begin
      base = MinBase;
    end else if (radix_q > MaxBase) begin
      base = MaxBase;
    end else begin
      base = radix_q;
    end
  end

  // shared multiplier for the upward power walk
  assign prod = ProdW'(pow_q) * ProdW'(base);
  assign fits = (prod[ProdW-1:W] == '0);

  // one restoring-division step
  assign trial = ProdW'(rd_q) << bit_q;
  assign ge = (ProdW'(rem_q) >= trial);
  assign digit = quo_q | (ge ? (RadixW'(1) << bit_q) : '0);
  assign emit_now = started_q || (digit != '0) || (idx_q == '0);

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    bit_d = bit_q;
    started_d = started_q;
    last_d = last_q;
    pow_d = pow_q;
    rem_d = rem_q;
    quo_d = quo_q;
    char_d = char_q;
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid_i) begin
          pow_d = W'(1);
          idx_d = '0;
          rem_d = s_axis_tdata_i[W-1:0];
          started_d = 1'b0;
          state_d = StFind;
        end
      end
      StFind: begin
        if (fits) begin
          pow_d = prod[W-1:0];
          idx_d = idx_q + IdxW'(1);
        end else begin
          state_d = StLoad;
        end
      end
      StLoad: begin
        bit_d = BitW'(RadixW - 1);
        quo_d = '0;
        state_d = StDiv;
      end
      StDiv: begin
        if (ge) begin
          rem_d = rem_q - trial[W-1:0];
        end
        quo_d = digit;
        if (bit_q == '0) begin
          started_d = started_q | (digit != '0);
          if (emit_now) begin
            char_d = digit_to_ascii(digit);
            last_d = (idx_q == '0);
            state_d = StEmit;
          end else begin
            idx_d = idx_q - IdxW'(1);
            state_d = StLoad;
          end
        end else begin
          bit_d = bit_q - BitW'(1);
        end
      end
      StEmit: begin
        if (m_axis_tready_i) begin
          if (last_q) begin
            state_d = StIdle;
          end else begin
            idx_d = idx_q - IdxW'(1);
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      radix_q <= RadixReset;
      idx_q <= '0;
      bit_q <= '0;
      started_q <= 1'b0;
      last_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      bit_q <= bit_d;
      started_q <= started_d;
      last_q <= last_d;
      if (cfg_we_i) begin
        radix_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pow_q <= pow_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    char_q <= char_d;
  end

  // power memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (state_q == StFind) begin
      pow_mem[idx_q] <= pow_q;
    end
    rd_q <= pow_mem[idx_q];
  end

  assign s_axis_tready_o = (state_q == StIdle);
  assign m_axis_tvalid_o = (state_q == StEmit);
  assign m_axis_tdata_o = {1'b0, char_q};
  assign m_axis_tlast_o = last_q;

  // digit words are always legal base-62 characters
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((char_q >= CharW'(48) && char_q <= CharW'(57)) ||
                         (char_q >= CharW'(97) && char_q <= CharW'(122)) ||
                         (char_q >= CharW'(65) && char_q <= CharW'(90))))
    else $error("digit word outside the base-62 alphabet");

  // never take a number while a digit is on offer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while a digit is pending");

  // a digit without tlast means more digits follow: stay busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o) |=> !s_axis_tready_o)
    else $error("returned to idle before the final digit");

  // an accepted number always starts the power walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == StFind && pow_q == W'(1)))
    else $error("power walk did not start at one");

endmodule

`default_nettype wire

// ----- tb/tb_integer_to_radix_digits_top.sv -----
`timescale 1ns / 1ps

// Testbench for the radix digit emitter.
// Numbers are streamed in; a local digit predictor queues the expected ASCII
// words for each accepted number. Every accepted output word is checked
// against the oldest queued word. Idle and stall rates change per test.
module tb_integer_to_radix_digits_top;
  import itrd_pkg::*;

  localparam int CycleLimit = 2_000_000;  // backstop, far above the slowest run
  localparam int TailCycles = 700;        // one base-2 number plus margin
  localparam int MaxReports = 10;
  localparam logic [ValueW-1:0] AllOnes = {ValueW{1'b1}};

  typedef struct packed {
    logic [CharW-1:0] code;
    logic             last;
  } digit_word_t;

  // DUT ports, inputs all driven from time zero
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [RadixW-1:0]   cfg_wdata_i = RadixReset;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [ValueW-1:0]   s_axis_tdata_i = '0;     // [63:0] value
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [CharBusW-1:0] m_axis_tdata_o;          // [6:0] digit_char, [7] zero
  logic                m_axis_tlast_o;

  // shadow of the radix register and the queue of expected digit words
  logic [RadixW-1:0] radix_shadow = RadixReset;
  digit_word_t       expected_digits[$];

  int send_idle_pct = 0;   // chance per cycle that the sender holds off
  int stall_pct = 0;       // chance per cycle that the sink drops tready
  int hold_request = 0;    // long sink hold-off, picked up by the sink process
  int hold_left = 0;
  int error_count = 0;
  int digits_checked = 0;
  int cycle_count = 0;

  integer_to_radix_digits_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Digit predictor
  // ---------------------------------------------------------------------------

  // 0 and 1 behave as base 2, 63 as base 62
  function automatic logic [ValueW-1:0] radix_to_base(input logic [RadixW-1:0] r);
    if (r < MinBase) begin
      return ValueW'(MinBase);
    end else if (r > MaxBase) begin
      return ValueW'(MaxBase);
    end
    return ValueW'(r);
  endfunction

  function automatic logic [CharW-1:0] digit_code(input logic [ValueW-1:0] d);
    logic [CharW-1:0] d7;
    d7 = d[CharW-1:0];
    if (d <= ValueW'(LastDecimal)) begin
      return d7 + CharZero;
    end else if (d <= ValueW'(LastLower)) begin
      return d7 + LowerOffset;
    end
    return d7 + UpperOffset;
  endfunction

  // Queue the digit words of one number: start at the largest power of the
  // base that fits, divide down, drop leading zeros; zero alone gives '0'.
  function automatic void predict_digits(input logic [ValueW-1:0] value);
    logic [ValueW-1:0] base;
    logic [ValueW-1:0] power;
    logic [ValueW-1:0] rest;
    logic [ValueW-1:0] d;
    logic [CharW-1:0]  codes[$];
    bit                seen;
    digit_word_t       w;
    base = radix_to_base(radix_shadow);
    power = 1;
    while (power <= AllOnes / base) begin
      power = power * base;
    end
    rest = value;
    seen = 1'b0;
    while (power != 0) begin
      d = rest / power;
      rest = rest - d * power;
      if (d != 0) begin
        seen = 1'b1;
      end
      if (seen) begin
        codes.push_back(digit_code(d));
      end
      power = power / base;
    end
    if (codes.size() == 0) begin
      codes.push_back(CharZero);
    end
    foreach (codes[i]) begin
      w.code = codes[i];
      w.last = (i == codes.size() - 1);
      expected_digits.push_back(w);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Shared helpers
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MaxReports) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Entered and left just after a falling edge. Holds tvalid across items
  // when no idle cycle is drawn, so tvalid is never lowered and raised in
  // the same step.
  task automatic send_number(input logic [ValueW-1:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= value;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_digits(value);
    @(negedge clk_i);
  endtask

  // drop tvalid and wait until every expected word has come back
  task automatic drain_numbers();
    s_axis_tvalid_i <= 1'b0;
    while (expected_digits.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // register write, only with the block idle
  task automatic set_radix(input logic [RadixW-1:0] r);
    drain_numbers();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= r;
    radix_shadow = r;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mix of full-width values, shifted-down values, zero and values around
  // powers of the current base, so short and long digit strings both occur.
  function automatic logic [ValueW-1:0] random_number();
    logic [ValueW-1:0] base;
    logic [ValueW-1:0] p;
    int                k;
    base = radix_to_base(radix_shadow);
    case ($urandom_range(7))
      0: return '0;
      1, 2: return {$urandom, $urandom} >> $urandom_range(ValueW - 1);
      3, 4: begin
        p = 1;
        k = $urandom_range(ValueW);
        while (k > 0 && p <= AllOnes / base) begin
          p = p * base;
          k--;
        end
        case ($urandom_range(2))
          0: return p;
          1: return p - 1;
          default: return p + ValueW'($urandom_range(base - 1));
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // random numbers with a fresh random radix every 13 numbers
  task automatic run_random_numbers(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 13 == 0) begin
        set_radix(RadixW'($urandom_range(63)));
      end
      send_number(random_number());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sink side and checking
  // ---------------------------------------------------------------------------

  always @(negedge clk_i) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin : check_digits
    digit_word_t w;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_digits.size() == 0) begin
        flag_error($sformatf("unexpected word tdata %02h last %0b",
                             m_axis_tdata_o, m_axis_tlast_o));
      end else begin
        w = expected_digits.pop_front();
        if (m_axis_tdata_o[CharW-1:0] !== w.code) begin
          flag_error($sformatf("word %0d: digit_char expected %02h got %02h",
                               digits_checked, w.code, m_axis_tdata_o[CharW-1:0]));
        end
        if (m_axis_tdata_o[CharBusW-1:CharW] !== '0) begin
          flag_error($sformatf("word %0d: pad bits expected 0 got %b",
                               digits_checked, m_axis_tdata_o[CharBusW-1:CharW]));
        end
        if (m_axis_tlast_o !== w.last) begin
          flag_error($sformatf("word %0d: last expected %0b got %0b",
                               digits_checked, w.last, m_axis_tlast_o));
        end
      end
      digits_checked++;
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // extremes of value and radix, out-of-range radix codes, zero input
  task automatic test_directed_cases();
    send_idle_pct = 0;
    stall_pct = 0;
    // reset radix, never written yet
    send_number('0);
    send_number(64'd1);
    send_number(AllOnes);
    send_number(64'd10_000_000_000_000_000_000);
    send_number(64'd9_999_999_999_999_999_999);
    set_radix(MinBase);
    send_number('0);
    send_number(AllOnes);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'd1);
    // radix codes below two act as base 2
    set_radix(RadixW'(0));
    send_number(64'd5);
    set_radix(RadixW'(1));
    send_number(64'd6);
    // code 63 acts as base 62
    set_radix(RadixW'(63));
    send_number(AllOnes);
    send_number(64'd61);
    send_number(64'd62);
    set_radix(MaxBase);
    send_number(AllOnes);
    send_number(64'd61);
    send_number(64'd36);
    send_number(64'd35);
    // lowercase range edges
    set_radix(RadixW'(36));
    send_number(64'd35);
    send_number(64'd10);
    send_number(64'd9);
    set_radix(RadixW'(16));
    send_number(64'hDEAD_BEEF_0123_4567);
  endtask

  task automatic test_random_streaming();
    send_idle_pct = 0;
    stall_pct = 0;
    run_random_numbers(46);
  endtask

  task automatic test_random_sender_idle();
    send_idle_pct = 81;
    stall_pct = 0;
    run_random_numbers(46);
  endtask

  task automatic test_random_receiver_stall();
    send_idle_pct = 0;
    stall_pct = 81;
    run_random_numbers(46);
  endtask

  task automatic test_random_both_idle();
    send_idle_pct = 25;
    stall_pct = 25;
    run_random_numbers(46);
  endtask

  // sink holds off for a long stretch while numbers keep coming, so the
  // block backs up and drops s_axis_tready
  task automatic test_input_backpressure();
    set_radix(RadixW'($urandom_range(63)));
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 1500;
    for (int i = 0; i < 8; i++) begin
      send_number(random_number());
    end
  endtask

  // sender waits for every digit of the previous number before the next
  task automatic test_drain_between_numbers();
    send_idle_pct = 0;
    stall_pct = 25;
    for (int i = 0; i < 6; i++) begin
      send_number(random_number());
      drain_numbers();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_streaming();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_input_backpressure();
    test_drain_between_numbers();

    drain_numbers();
    // any stray word during the tail is caught by the checker
    repeat (TailCycles) @(negedge clk_i);
    if (expected_digits.size() != 0) begin
      flag_error($sformatf("%0d expected words never arrived", expected_digits.size()));
    end
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- integer_to_radix_digits_top.f -----
hdl/itrd_pkg.sv
hdl/integer_to_radix_digits_top.sv
tb/tb_integer_to_radix_digits_top.sv
